>>> rtl/core/psl_pkg.sv
package psl_pkg;

  // Default sizing of the store
  localparam int DEPTH_DEF     = 16;
  localparam int ID_BITS_DEF   = 16;
  localparam int PRIO_BITS_DEF = 8;

  // Port field widths
  localparam int CMD_W    = 2;
  localparam int PID_W    = 16;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2,
    OP_SEARCH = 2'd3
  } psl_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } psl_status_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic    en;
    logic    full;
    psl_op_t op;
  } psl_ctrl_t;

endpackage

>>> rtl/core/psl_cell.sv
module psl_cell
  import psl_pkg::*;
#(
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psl_ctrl_t            ctrl,
  input  logic [ID_BITS-1:0]   key_id,
  input  logic [PRIO_BITS-1:0] key_prio,
  // neighbour towards the head
  input  logic                 prev_ge,
  input  logic                 prev_valid,
  input  logic [ID_BITS-1:0]   prev_id,
  input  logic [PRIO_BITS-1:0] prev_prio,
  // neighbour towards the tail
  input  logic                 next_valid,
  input  logic [ID_BITS-1:0]   next_id,
  input  logic [PRIO_BITS-1:0] next_prio,
  input  logic                 seen_in,
  output logic                 seen_out,
  output logic                 ge,
  output logic                 hit,
  output logic                 valid_q,
  output logic [ID_BITS-1:0]   id_q,
  output logic [PRIO_BITS-1:0] prio_q
);

  logic                 valid_r, valid_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic                 match;
  logic                 load_new;

  assign match    = valid_r && (id_r == key_id);
  assign ge       = valid_r && (prio_r >= key_prio);
  assign seen_out = seen_in | match;
  assign load_new = !ge && prev_ge;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    prio_nxt  = prio_r;
    hit       = 1'b0;
    case (ctrl.op)
      OP_CLEAR: begin
        valid_nxt = 1'b0;
      end
      OP_ADD: begin
        hit = load_new;
        if (!ctrl.full && !ge) begin
          if (prev_ge) begin
            valid_nxt = 1'b1;
            id_nxt    = key_id;
            prio_nxt  = key_prio;
          end else begin
            valid_nxt = prev_valid;
            id_nxt    = prev_id;
            prio_nxt  = prev_prio;
          end
        end
      end
      OP_DELETE: begin
        hit = match && !seen_in;
        // matched slot and all behind it pull from the tail side
        if (seen_out) begin
          valid_nxt = next_valid;
          id_nxt    = next_id;
          prio_nxt  = next_prio;
        end
      end
      OP_SEARCH: begin
        hit = match && !seen_in;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.en) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      id_r   <= id_nxt;
      prio_r <= prio_nxt;
    end
  end

  assign valid_q = valid_r;
  assign id_q    = id_r;
  assign prio_q  = prio_r;

endmodule

>>> rtl/core/priority_sorted_process_list_top.sv
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_cmd, in_proc_id, in_prio
// out_     output     out_valid/out_stall out_status, out_found_prio, out_position,
//                                        out_count, out_head_valid, out_head_id
//
// One transaction per cycle while in_stall is low: every cell of the chain
// compares against the broadcast key and shifts together, so a command completes at the edge
// that accepts it and its result is shown from the next cycle on.
// Reset (rst_n low, synchronous) empties the list and clears out_valid.
// in_stall is raised only while a result is held and out_stall is high; the
// list state, and so the head and count fields, stay frozen meanwhile.
module priority_sorted_process_list_top
  import psl_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [PID_W-1:0]    in_proc_id,
  input  logic [PRIO_W-1:0]   in_prio,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [PRIO_W-1:0]   out_found_prio,
  output logic [POS_W-1:0]    out_position,
  output logic [COUNT_W-1:0]  out_count,
  output logic                out_head_valid,
  output logic [PID_W-1:0]    out_head_id
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                 accept;
  psl_op_t              op;
  psl_ctrl_t            ctrl;
  logic [ID_BITS-1:0]   key_id;
  logic [PRIO_BITS-1:0] key_prio;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 full;
  logic                 found;

  // chain wiring
  logic                 ge_w    [DEPTH];
  logic                 hit_w   [DEPTH];
  logic                 valid_w [DEPTH];
  logic [ID_BITS-1:0]   id_w    [DEPTH];
  logic [PRIO_BITS-1:0] prio_w  [DEPTH];
  logic                 seen_w  [DEPTH+1];

  logic [IDX_W-1:0]     pos_sel;
  logic [PRIO_BITS-1:0] prio_sel;
  psl_status_t          status;

  logic                 out_valid_r;
  psl_status_t          status_r;
  logic [PRIO_W-1:0]    found_prio_r;
  logic [POS_W-1:0]     position_r;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign op       = psl_op_t'(in_cmd);
  assign key_id   = ID_BITS'(in_proc_id);
  assign key_prio = PRIO_BITS'(in_prio);
  assign full     = (count_r == CNT_W'(DEPTH));

  assign ctrl.en   = accept;
  assign ctrl.full = full;
  assign ctrl.op   = op;

  assign seen_w[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 p_ge, p_valid, n_valid;
    logic [ID_BITS-1:0]   p_id, n_id;
    logic [PRIO_BITS-1:0] p_prio, n_prio;

    if (i == 0) begin : g_head
      assign p_ge    = 1'b1;
      assign p_valid = 1'b0;
      assign p_id    = '0;
      assign p_prio  = '0;
    end else begin : g_mid
      assign p_ge    = ge_w[i-1];
      assign p_valid = valid_w[i-1];
      assign p_id    = id_w[i-1];
      assign p_prio  = prio_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_id    = '0;
      assign n_prio  = '0;
    end else begin : g_body
      assign n_valid = valid_w[i+1];
      assign n_id    = id_w[i+1];
      assign n_prio  = prio_w[i+1];
    end

    psl_cell #(
      .ID_BITS   (ID_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .key_id     (key_id),
      .key_prio   (key_prio),
      .prev_ge    (p_ge),
      .prev_valid (p_valid),
      .prev_id    (p_id),
      .prev_prio  (p_prio),
      .next_valid (n_valid),
      .next_id    (n_id),
      .next_prio  (n_prio),
      .seen_in    (seen_w[i]),
      .seen_out   (seen_w[i+1]),
      .ge         (ge_w[i]),
      .hit        (hit_w[i]),
      .valid_q    (valid_w[i]),
      .id_q       (id_w[i]),
      .prio_q     (prio_w[i])
    );
  end

  assign found = seen_w[DEPTH];

  // at most one cell hits: OR-reduce its index and priority
  always_comb begin
    pos_sel  = '0;
    prio_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_w[i]) begin
        pos_sel  = pos_sel | IDX_W'(i);
        prio_sel = prio_sel | prio_w[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    status    = ST_OK;
    case (op)
      OP_CLEAR: begin
        count_nxt = '0;
      end
      OP_ADD: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (found) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      OP_SEARCH: begin
        if (!found) begin
          status = ST_NOT_FOUND;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload; a failed command or a clear reports zeros
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status;
      if (status == ST_OK && op != OP_CLEAR) begin
        position_r <= POS_W'(pos_sel);
      end else begin
        position_r <= '0;
      end
      if (status == ST_OK && (op == OP_DELETE || op == OP_SEARCH)) begin
        found_prio_r <= PRIO_W'(prio_sel);
      end else begin
        found_prio_r <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_found_prio = found_prio_r;
  assign out_position   = position_r;
  // list state only moves on accept, so these track the last transaction
  assign out_count      = COUNT_W'(count_r);
  assign out_head_valid = valid_w[0];
  assign out_head_id    = valid_w[0] ? PID_W'(id_w[0]) : '0;

endmodule
